/* rtl/clct_pkg.sv */
// Shared types and constants for the C literal and comment tokenizer.
`default_nettype none

package clct_pkg;

   localparam int LINE_BITS   = 20;
   localparam int COLUMN_BITS = 16;
   localparam int LENGTH_BITS = 16;

   localparam logic [LINE_BITS-1:0]   LINE_MAX   = '1;
   localparam logic [COLUMN_BITS-1:0] COLUMN_MAX = '1;
   localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = '1;

   // Source characters the scanner reacts to.
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_SQUOTE  = 8'h27;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_SEVEN   = 8'h37;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UP_A    = 8'h41;
   localparam logic [7:0] CH_UP_F    = 8'h46;
   localparam logic [7:0] CH_UP_X    = 8'h58;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_LO_A    = 8'h61;
   localparam logic [7:0] CH_LO_F    = 8'h66;
   localparam logic [7:0] CH_LO_X    = 8'h78;

   typedef enum logic [2:0] {
      KIND_COMMENT = 3'd0,
      KIND_STRING  = 3'd1,
      KIND_CHAR    = 3'd2,
      KIND_MULTI   = 3'd3,
      KIND_NUMBER  = 3'd4,
      KIND_UNKNOWN = 3'd5
   } lex_kind_type;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       end_of_text;
   } req_payload_type;

   typedef struct packed {
      lex_kind_type             lex_kind;
      logic [LINE_BITS-1:0]     start_line;
      logic [COLUMN_BITS-1:0]   start_column;
      logic [LENGTH_BITS-1:0]   token_length;
   } rsp_payload_type;

endpackage

`default_nettype wire

/* rtl/c_literal_comment_tokenizer.sv */
// Streaming tokenizer for C comments, string/char literals and numbers.
//
//   channel | dir | handshake             | payload
//   --------+-----+-----------------------+-------------------------------------
//   req     | in  | req_valid / req_ready | char_byte, end_of_text
//   rsp     | out | rsp_valid / rsp_ready | lex_kind, start_line/column, length
//
// One byte per cycle: every accepted byte updates the scan state and the
// line/column counters in the same cycle, and a finished token is loaded into
// the rsp output register. A token can only be loaded when that register is
// empty or being drained, so req_ready = !rsp_valid | rsp_ready.
// Reset (synchronous, active high) returns to idle at line 1, column 1.
// The last byte of a text (end_of_text) flushes any open token but a lone
// slash and resets the position counters, so the next byte starts a new text.
`default_nettype none

module c_literal_comment_tokenizer (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire clct_pkg::req_payload_type req_payload,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output clct_pkg::rsp_payload_type      rsp_payload
);

   typedef enum logic [3:0] {
      S_IDLE, S_SLASH, S_LINE, S_BLOCK, S_BLOCK_STAR, S_STR, S_STR_ESC,
      S_CHR, S_CHR_ESC, S_ZERO, S_HEX, S_OCT, S_DEC, S_UNK
   } mode_type;

   mode_type                               mode_ff, mode_in, step_mode, begin_mode;
   logic [clct_pkg::LINE_BITS-1:0]         line_ff, line_in;
   logic [clct_pkg::COLUMN_BITS-1:0]       col_ff, col_in;
   logic [clct_pkg::LINE_BITS-1:0]         start_line_ff, start_line_in, step_start_line;
   logic [clct_pkg::COLUMN_BITS-1:0]       start_col_ff, start_col_in, step_start_col;
   logic [clct_pkg::LENGTH_BITS-1:0]       len_ff, len_in, step_len, len_grown;
   logic [1:0]                             lit_ff, lit_in, step_lit, lit_inc;
   logic                                   esc_ff, esc_in, step_esc;

   logic                                   rsp_valid_ff;
   clct_pkg::rsp_payload_type              rsp_payload_ff;
   logic                                   rsp_load;
   clct_pkg::rsp_payload_type              rsp_load_data;

   logic                                   accept;
   logic                                   emit;
   clct_pkg::lex_kind_type                 kind;
   clct_pkg::lex_kind_type                 char_kind;
   logic [7:0]                             b;
   logic                                   last;
   logic                                   is_blank, is_dec, is_oct, is_hex;

   assign b    = req_payload.char_byte;
   assign last = req_payload.end_of_text;

   assign is_blank = (b == clct_pkg::CH_SPACE) || (b == clct_pkg::CH_TAB);
   assign is_dec   = (b >= clct_pkg::CH_ZERO) && (b <= clct_pkg::CH_NINE);
   assign is_oct   = (b >= clct_pkg::CH_ZERO) && (b <= clct_pkg::CH_SEVEN);
   assign is_hex   = is_dec
                     || ((b >= clct_pkg::CH_LO_A) && (b <= clct_pkg::CH_LO_F))
                     || ((b >= clct_pkg::CH_UP_A) && (b <= clct_pkg::CH_UP_F));

   assign len_grown = (len_ff == clct_pkg::LENGTH_MAX) ? len_ff : len_ff + 1'b1;
   assign lit_inc   = (lit_ff == 2'd2) ? lit_ff : lit_ff + 1'b1;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Token kind a byte opens when the scanner is idle or after a lone slash.
   always_comb begin
      if (b == clct_pkg::CH_SLASH) begin
         begin_mode = S_SLASH;
      end else if (b == clct_pkg::CH_DQUOTE) begin
         begin_mode = S_STR;
      end else if (b == clct_pkg::CH_SQUOTE) begin
         begin_mode = S_CHR;
      end else if (b == clct_pkg::CH_ZERO) begin
         begin_mode = S_ZERO;
      end else if (is_dec) begin
         begin_mode = S_DEC;
      end else begin
         begin_mode = S_IDLE;
      end
   end

   // Per-byte scan step.
   always_comb begin
      logic do_begin;
      do_begin        = 1'b0;
      step_mode       = mode_ff;
      step_start_line = start_line_ff;
      step_start_col  = start_col_ff;
      step_len        = len_ff;
      step_lit        = lit_ff;
      step_esc        = esc_ff;
      emit            = 1'b0;
      kind            = clct_pkg::KIND_COMMENT;

      case (mode_ff)
         S_IDLE: begin
            do_begin = 1'b1;
         end
         S_SLASH: begin
            if (b == clct_pkg::CH_SLASH) begin
               step_mode = S_LINE;
               step_len  = len_grown;
            end else if (b == clct_pkg::CH_STAR) begin
               step_mode = S_BLOCK;
               step_len  = len_grown;
            end else begin
               step_mode = S_IDLE;
               do_begin  = 1'b1;
            end
         end
         S_LINE: begin
            if (b == clct_pkg::CH_NEWLINE) begin
               emit = 1'b1;
               kind = clct_pkg::KIND_COMMENT;
            end else begin
               step_len = len_grown;
            end
         end
         S_BLOCK: begin
            step_len = len_grown;
            if (b == clct_pkg::CH_STAR) step_mode = S_BLOCK_STAR;
         end
         S_BLOCK_STAR: begin
            step_len = len_grown;
            if (b == clct_pkg::CH_SLASH) begin
               emit = 1'b1;
               kind = clct_pkg::KIND_COMMENT;
            end else if (b != clct_pkg::CH_STAR) begin
               step_mode = S_BLOCK;
            end
         end
         S_STR: begin
            step_len = len_grown;
            if (b == clct_pkg::CH_BSLASH) begin
               step_mode = S_STR_ESC;
            end else if (b == clct_pkg::CH_DQUOTE) begin
               emit = 1'b1;
               kind = clct_pkg::KIND_STRING;
            end
         end
         S_STR_ESC: begin
            step_len  = len_grown;
            step_mode = S_STR;
         end
         S_CHR: begin
            step_len = len_grown;
            if (b == clct_pkg::CH_BSLASH) begin
               step_lit  = lit_inc;
               step_esc  = 1'b1;
               step_mode = S_CHR_ESC;
            end else if (b == clct_pkg::CH_SQUOTE) begin
               // closing quote leaves the char counts as they were
               emit = 1'b1;
               kind = (lit_ff <= 2'd1 || esc_ff) ? clct_pkg::KIND_CHAR
                                                 : clct_pkg::KIND_MULTI;
            end else begin
               step_lit = lit_inc;
            end
         end
         S_CHR_ESC: begin
            step_len  = len_grown;
            step_mode = S_CHR;
         end
         S_ZERO: begin
            if ((b == clct_pkg::CH_LO_X) || (b == clct_pkg::CH_UP_X)) begin
               step_mode = S_HEX;
               step_len  = len_grown;
            end else if (is_oct) begin
               step_mode = S_OCT;
               step_len  = len_grown;
            end else if (is_blank) begin
               emit = 1'b1;
               kind = clct_pkg::KIND_NUMBER;
            end else begin
               step_mode = S_UNK;
               step_len  = len_grown;
            end
         end
         S_HEX, S_OCT, S_DEC: begin
            if ((mode_ff == S_HEX && is_hex) || (mode_ff == S_OCT && is_oct)
                || (mode_ff == S_DEC && is_dec)) begin
               step_len = len_grown;
            end else if (is_blank) begin
               emit = 1'b1;
               kind = clct_pkg::KIND_NUMBER;
            end else begin
               step_mode = S_UNK;
               step_len  = len_grown;
            end
         end
         S_UNK: begin
            if (is_blank) begin
               emit = 1'b1;
               kind = clct_pkg::KIND_UNKNOWN;
            end else begin
               step_len = len_grown;
            end
         end
         default: begin
            step_mode = S_IDLE;
         end
      endcase

      // Opening byte of a new token (from idle or after a lone slash).
      if (do_begin && begin_mode != S_IDLE) begin
         step_mode       = begin_mode;
         step_start_line = line_ff;
         step_start_col  = col_ff;
         step_len        = {{(clct_pkg::LENGTH_BITS-1){1'b0}}, 1'b1};
         step_lit        = 2'd0;
         step_esc        = 1'b0;
      end

      if (emit) step_mode = S_IDLE;
   end

   // Char literal kind uses the counts after this byte.
   assign char_kind = (step_lit <= 2'd1 || step_esc) ? clct_pkg::KIND_CHAR
                                                     : clct_pkg::KIND_MULTI;

   // End-of-text flush and position update.
   always_comb begin
      logic                   flush;
      clct_pkg::lex_kind_type flush_kind;
      flush      = 1'b0;
      flush_kind = clct_pkg::KIND_COMMENT;

      if (b == clct_pkg::CH_NEWLINE) begin
         line_in = (line_ff == clct_pkg::LINE_MAX) ? line_ff : line_ff + 1'b1;
         col_in  = {{(clct_pkg::COLUMN_BITS-1){1'b0}}, 1'b1};
      end else begin
         line_in = line_ff;
         col_in  = (col_ff == clct_pkg::COLUMN_MAX) ? col_ff : col_ff + 1'b1;
      end

      mode_in       = step_mode;
      start_line_in = step_start_line;
      start_col_in  = step_start_col;
      len_in        = step_len;
      lit_in        = step_lit;
      esc_in        = step_esc;

      if (last) begin
         if (!emit) begin
            case (step_mode)
               S_LINE, S_BLOCK, S_BLOCK_STAR: begin
                  flush      = 1'b1;
                  flush_kind = clct_pkg::KIND_COMMENT;
               end
               S_STR, S_STR_ESC: begin
                  flush      = 1'b1;
                  flush_kind = clct_pkg::KIND_STRING;
               end
               S_CHR, S_CHR_ESC: begin
                  flush      = 1'b1;
                  flush_kind = char_kind;
               end
               S_ZERO, S_HEX, S_OCT, S_DEC, S_UNK: begin
                  flush      = 1'b1;
                  flush_kind = clct_pkg::KIND_UNKNOWN;
               end
               default: begin
                  flush = 1'b0;
               end
            endcase
         end
         mode_in       = S_IDLE;
         line_in       = {{(clct_pkg::LINE_BITS-1){1'b0}}, 1'b1};
         col_in        = {{(clct_pkg::COLUMN_BITS-1){1'b0}}, 1'b1};
         start_line_in = '0;
         start_col_in  = '0;
         len_in        = '0;
         lit_in        = 2'd0;
         esc_in        = 1'b0;
      end

      // Result fields come from the step values, before the end-of-text clear.
      rsp_load      = emit || flush;
      rsp_load_data = '{lex_kind:     emit ? kind : flush_kind,
                        start_line:   step_start_line,
                        start_column: step_start_col,
                        token_length: step_len};
   end

   // Scan state and counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= S_IDLE;
         line_ff       <= {{(clct_pkg::LINE_BITS-1){1'b0}}, 1'b1};
         col_ff        <= {{(clct_pkg::COLUMN_BITS-1){1'b0}}, 1'b1};
         start_line_ff <= '0;
         start_col_ff  <= '0;
         len_ff        <= '0;
         lit_ff        <= 2'd0;
         esc_ff        <= 1'b0;
      end else if (accept) begin
         mode_ff       <= mode_in;
         line_ff       <= line_in;
         col_ff        <= col_in;
         start_line_ff <= start_line_in;
         start_col_ff  <= start_col_in;
         len_ff        <= len_in;
         lit_ff        <= lit_in;
         esc_ff        <= esc_in;
      end
   end

   // Output register: holds one token until its transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && rsp_load) begin
         rsp_payload_ff <= rsp_load_data;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // A byte flagged as last always leaves the scanner fresh.
   a_eot_resets: assert property (@(posedge clock) disable iff (reset)
      accept && last |=> mode_ff == S_IDLE && line_ff == 1 && col_ff == 1
                          && len_ff == 0)
      else $error("end of text did not reset scan state");

   // Every delivered token has at least one byte and a real position.
   a_token_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_payload_ff.token_length != 0
                       && rsp_payload_ff.start_line != 0
                       && rsp_payload_ff.start_column != 0)
      else $error("token with zero length or position");

   // A pending token is never overwritten by a new one.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !accept)
      else $error("byte accepted while output register is full");

   // Token length stays one while a lone slash waits for its second byte.
   a_slash_len: assert property (@(posedge clock) disable iff (reset)
      mode_ff == S_SLASH |-> len_ff == 1)
      else $error("slash pending with wrong length");

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the C literal and comment tokenizer.
`timescale 1ns / 1ps

module tb;

   // Scanner states of the behavioral predictor.
   typedef enum logic [3:0] {
      SCAN_IDLE,
      SCAN_SLASH,
      SCAN_LINE,
      SCAN_BLOCK,
      SCAN_BLOCK_STAR,
      SCAN_STR,
      SCAN_STR_ESC,
      SCAN_CHR,
      SCAN_CHR_ESC,
      SCAN_ZERO,
      SCAN_HEX,
      SCAN_OCT,
      SCAN_DEC,
      SCAN_UNK
   } scan_state_type;

   localparam int CYCLE_LIMIT      = 1_000_000;
   localparam int BYTES_PER_PHASE  = 290;   // four phases, at least 1160 bytes
   localparam int DRAIN_CYCLES     = 16;

   // Clock, reset and DUT-facing signals; every input is known from time 0.
   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_ready;
   clct_pkg::req_payload_type req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_ready   = 1'b0;
   clct_pkg::rsp_payload_type rsp_payload;

   // Bytes waiting to be driven, tokens waiting to come back.
   clct_pkg::req_payload_type source_q[$];
   clct_pkg::rsp_payload_type token_q[$];
   logic [7:0]                frag_q[$];   // one random text under construction

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned queued_count   = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   bit          req_taken      = 1'b0;

   // Predictor state: position counters and the open token.
   scan_state_type                     scan_state;
   logic [clct_pkg::LINE_BITS-1:0]     cur_line;
   logic [clct_pkg::COLUMN_BITS-1:0]   cur_col;
   logic [clct_pkg::LINE_BITS-1:0]     tok_line;
   logic [clct_pkg::COLUMN_BITS-1:0]   tok_col;
   logic [clct_pkg::LENGTH_BITS-1:0]   tok_len;
   logic [1:0]                         lit_chars;   // 0, 1, 2 = two or more
   logic                               esc_seen;

   c_literal_comment_tokenizer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   function automatic bit is_blank(input logic [7:0] b);
      return b == clct_pkg::CH_SPACE || b == clct_pkg::CH_TAB;
   endfunction

   function automatic bit is_dec(input logic [7:0] b);
      return b >= clct_pkg::CH_ZERO && b <= clct_pkg::CH_NINE;
   endfunction

   function automatic bit is_oct(input logic [7:0] b);
      return b >= clct_pkg::CH_ZERO && b <= clct_pkg::CH_SEVEN;
   endfunction

   function automatic bit is_hex(input logic [7:0] b);
      return is_dec(b)
             || (b >= clct_pkg::CH_LO_A && b <= clct_pkg::CH_LO_F)
             || (b >= clct_pkg::CH_UP_A && b <= clct_pkg::CH_UP_F);
   endfunction

   task automatic clear_scan();
      scan_state = SCAN_IDLE;
      cur_line   = {{(clct_pkg::LINE_BITS-1){1'b0}}, 1'b1};
      cur_col    = {{(clct_pkg::COLUMN_BITS-1){1'b0}}, 1'b1};
      tok_line   = '0;
      tok_col    = '0;
      tok_len    = '0;
      lit_chars  = '0;
      esc_seen   = 1'b0;
   endtask

   task automatic grow_len();
      if (tok_len != clct_pkg::LENGTH_MAX) tok_len++;
   endtask

   task automatic count_char();
      if (lit_chars < 2'd2) lit_chars++;
   endtask

   // Escapes always make a plain char literal; two or more bare chars do not.
   function automatic clct_pkg::lex_kind_type char_kind();
      return (lit_chars <= 2'd1 || esc_seen) ? clct_pkg::KIND_CHAR : clct_pkg::KIND_MULTI;
   endfunction

   task automatic close_token(input clct_pkg::lex_kind_type kind, output logic emits,
                              output clct_pkg::rsp_payload_type tok);
      tok.lex_kind     = kind;
      tok.start_line   = tok_line;
      tok.start_column = tok_col;
      tok.token_length = tok_len;
      scan_state       = SCAN_IDLE;
      emits            = 1'b1;
   endtask

   // A byte seen while idle may open a token; anything else is skipped.
   task automatic open_token(input logic [7:0] b,
                             input logic [clct_pkg::LINE_BITS-1:0] ln,
                             input logic [clct_pkg::COLUMN_BITS-1:0] col);
      scan_state_type nxt;
      nxt = SCAN_IDLE;
      if (b == clct_pkg::CH_SLASH) nxt = SCAN_SLASH;
      else if (b == clct_pkg::CH_DQUOTE) nxt = SCAN_STR;
      else if (b == clct_pkg::CH_SQUOTE) nxt = SCAN_CHR;
      else if (b == clct_pkg::CH_ZERO) nxt = SCAN_ZERO;
      else if (is_dec(b)) nxt = SCAN_DEC;
      if (nxt != SCAN_IDLE) begin
         scan_state = nxt;
         tok_line   = ln;
         tok_col    = col;
         tok_len    = {{(clct_pkg::LENGTH_BITS-1){1'b0}}, 1'b1};
         lit_chars  = '0;
         esc_seen   = 1'b0;
      end
   endtask

   // Digits extend a number; a blank ends it; anything else makes it unknown.
   task automatic number_byte(input logic [7:0] b, input bit keep, output logic emits,
                              output clct_pkg::rsp_payload_type tok);
      emits = 1'b0;
      tok   = '0;
      if (keep) grow_len();
      else if (is_blank(b)) close_token(clct_pkg::KIND_NUMBER, emits, tok);
      else begin
         scan_state = SCAN_UNK;
         grow_len();
      end
   endtask

   task automatic lex_byte(input logic [7:0] b, input logic last, output logic emits,
                           output clct_pkg::rsp_payload_type tok);
      logic [clct_pkg::LINE_BITS-1:0]   ln;
      logic [clct_pkg::COLUMN_BITS-1:0] col;
      ln    = cur_line;
      col   = cur_col;
      emits = 1'b0;
      tok   = '0;
      case (scan_state)
         SCAN_IDLE: open_token(b, ln, col);
         SCAN_SLASH: begin
            if (b == clct_pkg::CH_SLASH) begin
               scan_state = SCAN_LINE;
               grow_len();
            end else if (b == clct_pkg::CH_STAR) begin
               scan_state = SCAN_BLOCK;
               grow_len();
            end else begin
               scan_state = SCAN_IDLE;
               open_token(b, ln, col);
            end
         end
         SCAN_LINE: begin
            if (b == clct_pkg::CH_NEWLINE) close_token(clct_pkg::KIND_COMMENT, emits, tok);
            else grow_len();
         end
         SCAN_BLOCK: begin
            grow_len();
            if (b == clct_pkg::CH_STAR) scan_state = SCAN_BLOCK_STAR;
         end
         SCAN_BLOCK_STAR: begin
            grow_len();
            if (b == clct_pkg::CH_SLASH) close_token(clct_pkg::KIND_COMMENT, emits, tok);
            else if (b != clct_pkg::CH_STAR) scan_state = SCAN_BLOCK;
         end
         SCAN_STR: begin
            grow_len();
            if (b == clct_pkg::CH_BSLASH) scan_state = SCAN_STR_ESC;
            else if (b == clct_pkg::CH_DQUOTE) close_token(clct_pkg::KIND_STRING, emits, tok);
         end
         SCAN_STR_ESC: begin
            grow_len();
            scan_state = SCAN_STR;
         end
         SCAN_CHR: begin
            grow_len();
            if (b == clct_pkg::CH_BSLASH) begin
               count_char();
               esc_seen   = 1'b1;
               scan_state = SCAN_CHR_ESC;
            end else if (b == clct_pkg::CH_SQUOTE) begin
               close_token(char_kind(), emits, tok);
            end else begin
               count_char();
            end
         end
         SCAN_CHR_ESC: begin
            grow_len();
            scan_state = SCAN_CHR;
         end
         SCAN_ZERO: begin
            if (b == clct_pkg::CH_LO_X || b == clct_pkg::CH_UP_X) begin
               scan_state = SCAN_HEX;
               grow_len();
            end else if (is_oct(b)) begin
               scan_state = SCAN_OCT;
               grow_len();
            end else begin
               number_byte(b, 1'b0, emits, tok);
            end
         end
         SCAN_HEX: number_byte(b, is_hex(b), emits, tok);
         SCAN_OCT: number_byte(b, is_oct(b), emits, tok);
         SCAN_DEC: number_byte(b, is_dec(b), emits, tok);
         SCAN_UNK: begin
            if (is_blank(b)) close_token(clct_pkg::KIND_UNKNOWN, emits, tok);
            else grow_len();
         end
         default: scan_state = SCAN_IDLE;
      endcase

      if (b == clct_pkg::CH_NEWLINE) begin
         if (cur_line != clct_pkg::LINE_MAX) cur_line++;
         cur_col = {{(clct_pkg::COLUMN_BITS-1){1'b0}}, 1'b1};
      end else if (cur_col != clct_pkg::COLUMN_MAX) begin
         cur_col++;
      end

      // End of text flushes the open token, then everything starts over.
      if (last) begin
         if (!emits) begin
            case (scan_state)
               SCAN_LINE, SCAN_BLOCK, SCAN_BLOCK_STAR:
                  close_token(clct_pkg::KIND_COMMENT, emits, tok);
               SCAN_STR, SCAN_STR_ESC:
                  close_token(clct_pkg::KIND_STRING, emits, tok);
               SCAN_CHR, SCAN_CHR_ESC:
                  close_token(char_kind(), emits, tok);
               SCAN_ZERO, SCAN_HEX, SCAN_OCT, SCAN_DEC, SCAN_UNK:
                  close_token(clct_pkg::KIND_UNKNOWN, emits, tok);
               default: ;
            endcase
         end
         clear_scan();
      end
   endtask

   // ---------------------------------------------------------------------
   // Stimulus builders
   // ---------------------------------------------------------------------

   task automatic queue_byte(input logic [7:0] b, input logic last);
      clct_pkg::req_payload_type item;
      item.char_byte   = b;
      item.end_of_text = last;
      source_q.push_back(item);
      queued_count++;
   endtask

   task automatic queue_str(input string s, input bit last);
      for (int i = 0; i < s.len(); i++) queue_byte(s[i], last && i == s.len() - 1);
   endtask

   // Token body: mostly letters and digits, some blanks, some raw bytes.
   function automatic logic [7:0] body_byte();
      int unsigned pick;
      logic [7:0]  b;
      pick = $urandom_range(9);
      if (pick < 6) begin
         b = "a";
         b = b + 8'($urandom_range(25));
      end else if (pick == 6) begin
         b = clct_pkg::CH_ZERO + 8'($urandom_range(9));
      end else if (pick == 7) begin
         b = clct_pkg::CH_SPACE;
      end else begin
         b = 8'($urandom_range(255));
      end
      return b;
   endfunction

   function automatic logic [7:0] blank_byte();
      return $urandom_range(1) ? clct_pkg::CH_SPACE : clct_pkg::CH_TAB;
   endfunction

   // Quoted body where a backslash takes any following byte with it.
   task automatic add_quoted(input logic [7:0] quote, input int unsigned max_chars);
      int unsigned n;
      n = $urandom_range(max_chars);
      frag_q.push_back(quote);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(4) == 0) begin
            frag_q.push_back(clct_pkg::CH_BSLASH);
            frag_q.push_back($urandom_range(3) == 0 ? quote : body_byte());
         end else begin
            frag_q.push_back(body_byte());
         end
      end
      frag_q.push_back(quote);
   endtask

   task automatic add_number();
      string       hex_digits;
      int unsigned n;
      hex_digits = "0123456789abcdefABCDEF";
      n = $urandom_range(4);
      case ($urandom_range(2))
         0: begin
            frag_q.push_back(clct_pkg::CH_ZERO);
            frag_q.push_back($urandom_range(1) ? clct_pkg::CH_LO_X : clct_pkg::CH_UP_X);
            for (int i = 0; i < n; i++)
               frag_q.push_back(hex_digits[$urandom_range(hex_digits.len() - 1)]);
         end
         1: begin
            frag_q.push_back(clct_pkg::CH_ZERO);
            for (int i = 0; i < n; i++)
               frag_q.push_back(clct_pkg::CH_ZERO + 8'($urandom_range(7)));
         end
         default: begin
            frag_q.push_back(clct_pkg::CH_ZERO + 8'($urandom_range(1, 9)));
            for (int i = 0; i < n; i++)
               frag_q.push_back(clct_pkg::CH_ZERO + 8'($urandom_range(9)));
         end
      endcase
      // A stray suffix can turn the number into an unknown run.
      if ($urandom_range(3) == 0) begin
         for (int i = 0; i < $urandom_range(1, 3); i++) frag_q.push_back(body_byte());
      end
      frag_q.push_back(blank_byte());
   endtask

   task automatic add_token();
      int unsigned n;
      case ($urandom_range(8))
         0: begin   // line comment
            frag_q.push_back(clct_pkg::CH_SLASH);
            frag_q.push_back(clct_pkg::CH_SLASH);
            n = $urandom_range(6);
            for (int i = 0; i < n; i++) frag_q.push_back(body_byte());
            if ($urandom_range(9) < 7) frag_q.push_back(clct_pkg::CH_NEWLINE);
         end
         1: begin   // block comment, stars and slashes inside
            frag_q.push_back(clct_pkg::CH_SLASH);
            frag_q.push_back(clct_pkg::CH_STAR);
            n = $urandom_range(8);
            for (int i = 0; i < n; i++) begin
               case ($urandom_range(3))
                  0: frag_q.push_back(clct_pkg::CH_STAR);
                  1: frag_q.push_back(clct_pkg::CH_SLASH);
                  default: frag_q.push_back(body_byte());
               endcase
            end
            frag_q.push_back(clct_pkg::CH_STAR);
            frag_q.push_back(clct_pkg::CH_SLASH);
         end
         2: add_quoted(clct_pkg::CH_DQUOTE, 6);
         3, 4: add_quoted(clct_pkg::CH_SQUOTE, 3);
         5: add_number();
         6: begin   // lone slash
            frag_q.push_back(clct_pkg::CH_SLASH);
            frag_q.push_back(body_byte());
         end
         7: frag_q.push_back(clct_pkg::CH_NEWLINE);
         default: frag_q.push_back(8'($urandom_range(255)));   // noise
      endcase
   endtask

   // One text: a few tokens, sometimes cut short before its end flag.
   task automatic queue_text();
      int unsigned n_tok;
      int unsigned cut;
      frag_q.delete();
      n_tok = $urandom_range(1, 10);
      for (int i = 0; i < n_tok; i++) begin
         add_token();
         if ($urandom_range(4) != 0) begin
            frag_q.push_back($urandom_range(3) == 0 ? clct_pkg::CH_NEWLINE : blank_byte());
         end
      end
      if ($urandom_range(3) == 0) begin
         cut = $urandom_range(1, 3);
         while (cut != 0 && frag_q.size() > 1) begin
            void'(frag_q.pop_back());
            cut--;
         end
      end
      for (int i = 0; i < frag_q.size(); i++) queue_byte(frag_q[i], i == frag_q.size() - 1);
   endtask

   // ---------------------------------------------------------------------
   // Driver: new bytes and ready change on the falling edge only
   // ---------------------------------------------------------------------

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         // Hold a byte that has not transferred yet; otherwise maybe present the next.
         if (!req_valid || req_taken) begin
            if (source_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid   <= 1'b1;
               req_payload <= source_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
      req_taken = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Monitor: sample both channels on the rising edge
   // ---------------------------------------------------------------------

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] seen);
      if (seen !== want) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, seen);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      logic                      emits;
      clct_pkg::rsp_payload_type next_tok;
      clct_pkg::rsp_payload_type want;
      if (!reset) begin
         // Results first: a token can never leave in the edge its byte enters.
         if (rsp_valid && rsp_ready) begin
            if (token_q.size() == 0) begin
               $display({"%0t: unexpected token: expected none, ",
                         "actual kind %0d line %0d col %0d len %0d"},
                        $time, rsp_payload.lex_kind, rsp_payload.start_line,
                        rsp_payload.start_column, rsp_payload.token_length);
               mismatch_count++;
            end else begin
               want = token_q.pop_front();
               check_field("lex_kind", want.lex_kind, rsp_payload.lex_kind);
               check_field("start_line", want.start_line, rsp_payload.start_line);
               check_field("start_column", want.start_column, rsp_payload.start_column);
               check_field("token_length", want.token_length, rsp_payload.token_length);
            end
         end
         if (req_valid && req_ready) begin
            req_taken = 1'b1;
            lex_byte(req_payload.char_byte, req_payload.end_of_text, emits, next_tok);
            if (emits) token_q.push_back(next_tok);
         end
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("c_literal_comment_tokenizer regression: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer: reset, then four idling phases
   // ---------------------------------------------------------------------

   int unsigned send_pct_by_phase[4] = '{0, 83, 0, 33};
   int unsigned recv_pct_by_phase[4] = '{0, 0, 83, 33};

   initial begin
      int unsigned phase_start;
      clear_scan();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = send_pct_by_phase[p];
         recv_stall_pct = recv_pct_by_phase[p];
         if (p == 0) begin
            // Lone slash before a multichar literal, escaped quote char, hex, octal,
            // decimal run turned unknown by a letter and ended at a tab, line comment
            // carrying NUL and 0xFF, block comment closed by a double star.
            queue_str("/'ab''\\''0x1F 07 9z\t//", 1'b0);
            queue_byte(8'h00, 1'b0);
            queue_byte(8'hFF, 1'b0);
            queue_str("\n/*a**/", 1'b0);
            // Open string cut in its escape, then a lone digit and a lone
            // slash each forming a whole text of one byte.
            queue_str("\"\\", 1'b1);
            queue_str("0", 1'b1);
            queue_str("/", 1'b1);
         end
         phase_start = queued_count;
         while (queued_count - phase_start < BYTES_PER_PHASE) queue_text();
         while (source_q.size() != 0 || req_valid) @(posedge clock);
      end

      while (token_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && token_q.size() == 0) begin
         $display("c_literal_comment_tokenizer regression: pass");
      end else begin
         $display("c_literal_comment_tokenizer regression: fail");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/clct_pkg.sv
rtl/c_literal_comment_tokenizer.sv
tb/tb.sv
